[hdl/occfm_pkg.sv]
// Shared constants for the occupancy frontier mask: register indexes, field widths,
// reset values and the bit positions of the per-cell class flags.
// No dependencies.
`default_nettype none

package occfm_pkg;

   // Default geometry limits for the line store and counters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Control register indexes.
   localparam logic [2:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_FREE_THRESH  = 3'd2;
   localparam logic [2:0] CSR_OCC_THRESH   = 3'd3;
   localparam logic [2:0] CSR_REQUIRE_OCC  = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Register reset values.
   localparam int GRID_WIDTH_RST   = 1024;
   localparam int GRID_HEIGHT_RST  = 1024;
   localparam int FREE_THRESH_RST  = 25;
   localparam int OCC_THRESH_RST   = 65;

   // Fixed payload widths.
   localparam int CELL_COL_W = 10;
   localparam int CELL_ROW_W = 12;

   // Bit positions inside one 3-bit class flag group.
   localparam int FLAG_FREE = 0;
   localparam int FLAG_UNK  = 1;
   localparam int FLAG_OCC  = 2;

   typedef logic [2:0] flags_type;

endpackage

`default_nettype wire

[hdl/occupancy_frontier_mask.sv]
// A request is registered in stage 1, then its result (if any) in the output register.
// Throughput: one request per cycle while no result is held in stage 1 by rsp_stall.
// Only interior cells give a result; border cells pass through without one.
// Reset clears the counters, the 3x3 flag window, the pipeline valids and restores the
// control registers to their defaults. The line store needs no clearing pass.
`default_nettype none

module occupancy_frontier_mask #(
   parameter int MAX_WIDTH  = occfm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = occfm_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Cell request channel.
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic signed [7:0]                  req_cell_value,
   // Result channel.
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [occfm_pkg::CELL_COL_W-1:0]   rsp_cell_col,
   output      logic [occfm_pkg::CELL_ROW_W-1:0]   rsp_cell_row,
   output      logic                               rsp_is_frontier,
   output      logic                               rsp_frame_last,
   // Control register write channel.
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [occfm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [occfm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Column counter holds values below MAX_WIDTH; the clamped width itself needs
   // one more code, so it lives in a register sized to hold MAX_WIDTH itself.
   localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP = (WW > 11) ? WW : 11;
   localparam int HCMP = (HW > 13) ? HW : 13;
   localparam int W_RST = (occfm_pkg::GRID_WIDTH_RST  > MAX_WIDTH)  ? MAX_WIDTH :
                          occfm_pkg::GRID_WIDTH_RST;
   localparam int H_RST = (occfm_pkg::GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT :
                          occfm_pkg::GRID_HEIGHT_RST;

   //--------------------------------------------------------------------------
   // Control registers. The grid size is clamped to its legal range when it is
   // written, so everything downstream sees the saturated geometry.
   //--------------------------------------------------------------------------
   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [6:0]    free_thr_ff, free_thr_in;
   logic [6:0]    occ_thr_ff,  occ_thr_in;
   logic          req_occ_ff,  req_occ_in;

   logic [WCMP-1:0] wr_width;
   logic [HCMP-1:0] wr_height;

   assign csr_ready = 1'b1;
   assign wr_width  = WCMP'(csr_wdata[10:0]);
   assign wr_height = HCMP'(csr_wdata[12:0]);

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      free_thr_in = free_thr_ff;
      occ_thr_in  = occ_thr_ff;
      req_occ_in  = req_occ_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            occfm_pkg::CSR_GRID_WIDTH: begin
               if (wr_width < WCMP'(3))
                  width_in = WW'(3);
               else if (wr_width > WCMP'(MAX_WIDTH))
                  width_in = WW'(MAX_WIDTH);
               else
                  width_in = WW'(wr_width);
            end
            occfm_pkg::CSR_GRID_HEIGHT: begin
               if (wr_height < HCMP'(3))
                  height_in = HW'(3);
               else if (wr_height > HCMP'(MAX_HEIGHT))
                  height_in = HW'(MAX_HEIGHT);
               else
                  height_in = HW'(wr_height);
            end
            occfm_pkg::CSR_FREE_THRESH: free_thr_in = csr_wdata[6:0];
            occfm_pkg::CSR_OCC_THRESH:  occ_thr_in  = csr_wdata[6:0];
            occfm_pkg::CSR_REQUIRE_OCC: req_occ_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(W_RST);
         height_ff   <= HW'(H_RST);
         free_thr_ff <= 7'(occfm_pkg::FREE_THRESH_RST);
         occ_thr_ff  <= 7'(occfm_pkg::OCC_THRESH_RST);
         req_occ_ff  <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         free_thr_ff <= free_thr_in;
         occ_thr_ff  <= occ_thr_in;
         req_occ_ff  <= req_occ_in;
      end
   end

   //--------------------------------------------------------------------------
   // Stage 0: accept a request, classify the cell, work out its position and
   // whether it closes an interior window, and launch the line store read.
   //--------------------------------------------------------------------------
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_advance;
   logic            out_free;
   logic            req_accept;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            col_wrap;
   logic            row_wrap;

   occfm_pkg::flags_type cur_flags;
   logic            emit_now;
   logic            last_now;

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cur_flags = '0;
      cur_flags[occfm_pkg::FLAG_UNK]  = req_cell_value[7];
      cur_flags[occfm_pkg::FLAG_FREE] = !req_cell_value[7] &&
                                        (req_cell_value[6:0] < free_thr_ff);
      cur_flags[occfm_pkg::FLAG_OCC]  = !req_cell_value[7] &&
                                        (req_cell_value[6:0] >= occ_thr_ff);
   end

   assign col_wrap = (WW'(col_ff) + WW'(1)) >= width_ff;
   assign row_wrap = (HW'(row_ff) + HW'(1)) >= height_ff;

   assign emit_now = (col_ff >= CW'(2)) && (WW'(col_ff) < width_ff) &&
                     (row_ff >= RW'(2)) && (HW'(row_ff) < height_ff);
   assign last_now = (WW'(col_ff) == (width_ff - WW'(1))) &&
                     (HW'(row_ff) == (height_ff - HW'(1)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   //--------------------------------------------------------------------------
   // Line store. Each entry holds the flags of one column for the two rows
   // above the current one: {row above, two rows above}. The read is issued at
   // accept and the entry is rewritten as the item leaves stage 1. The same
   // column comes back no sooner than three requests later, so the write
   // always lands before the next read of that entry.
   //--------------------------------------------------------------------------
   logic [5:0] line_mem [MAX_WIDTH];
   logic [5:0] line_rd_ff;

   always_ff @(posedge clock) begin
      if (req_accept)
         line_rd_ff <= line_mem[col_ff];
   end

   // Stage 1 payload registers.
   occfm_pkg::flags_type           s1_flags_ff;
   logic [CW-1:0]                  s1_col_ff;
   logic                           s1_emit_ff;
   logic                           s1_last_ff;
   logic [occfm_pkg::CELL_COL_W-1:0] s1_out_col_ff;
   logic [occfm_pkg::CELL_ROW_W-1:0] s1_out_row_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flags_ff   <= cur_flags;
         s1_col_ff     <= col_ff;
         s1_emit_ff    <= emit_now;
         s1_last_ff    <= last_now;
         s1_out_col_ff <= occfm_pkg::CELL_COL_W'(col_ff - CW'(1));
         s1_out_row_ff <= occfm_pkg::CELL_ROW_W'(row_ff - RW'(1));
      end
   end

   //--------------------------------------------------------------------------
   // Stage 1: merge the line store data with the new cell into a fresh window
   // column, shift the 3x3 window, write the entry back and judge the center.
   // An item that gives no result never waits for the output register.
   //--------------------------------------------------------------------------
   assign out_free   = !rsp_valid || !rsp_stall;
   assign s1_advance = s1_valid_ff && (out_free || !s1_emit_ff);
   assign req_stall  = s1_valid_ff && !s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (s1_advance)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_advance)
         line_mem[s1_col_ff] <= {s1_flags_ff, line_rd_ff[5:3]};
   end

   // Window layout: three columns of nine bits, oldest at the bottom; inside a
   // column the top row sits in the low three bits.
   logic [26:0] window_ff, window_in;
   logic [8:0]  new_column;

   assign new_column = {s1_flags_ff, line_rd_ff[5:3], line_rd_ff[2:0]};

   always_comb begin
      window_in = window_ff;
      if (s1_advance)
         window_in = {new_column, window_ff[26:9]};
   end

   always_ff @(posedge clock) begin
      if (reset)
         window_ff <= '0;
      else
         window_ff <= window_in;
   end

   // Judgment on the shifted window.
   occfm_pkg::flags_type w00, w01, w02, w10, w11, w12, w20, w21, w22;
   occfm_pkg::flags_type unk_or, occ_or;
   logic                 frontier;

   always_comb begin
      w00 = window_in[2:0];
      w01 = window_in[5:3];
      w02 = window_in[8:6];
      w10 = window_in[11:9];
      w11 = window_in[14:12];
      w12 = window_in[17:15];
      w20 = window_in[20:18];
      w21 = window_in[23:21];
      w22 = window_in[26:24];
      // The unknown test looks at the four direct neighbors only, the
      // occupied test at all eight.
      unk_or = w10 | w12 | w01 | w21;
      occ_or = w00 | w01 | w02 | w10 | w12 | w20 | w21 | w22;
      frontier = w11[occfm_pkg::FLAG_FREE] && unk_or[occfm_pkg::FLAG_UNK];
      if (req_occ_ff && !occ_or[occfm_pkg::FLAG_OCC])
         frontier = 1'b0;
   end

   //--------------------------------------------------------------------------
   // Output register.
   //--------------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;

   assign rsp_load = s1_advance && s1_emit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   logic [occfm_pkg::CELL_COL_W-1:0] rsp_col_ff;
   logic [occfm_pkg::CELL_ROW_W-1:0] rsp_row_ff;
   logic                             rsp_frontier_ff;
   logic                             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff      <= s1_out_col_ff;
         rsp_row_ff      <= s1_out_row_ff;
         rsp_frontier_ff <= frontier;
         rsp_last_ff     <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_col    = rsp_col_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_is_frontier = rsp_frontier_ff;
   assign rsp_frame_last  = rsp_last_ff;

endmodule

`default_nettype wire
